// ===== hw/rtl/lottery_draw_scheduler_core_defines.svh =====
// Assertion macros shared by the lottery draw scheduler RTL.
`ifndef LOTTERY_DRAW_SCHEDULER_CORE_DEFINES_SVH
`define LOTTERY_DRAW_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lds_pkg.sv =====
// Shared types, constants and control store of the lottery draw scheduler.
package lds_pkg;

  localparam int NW     = 5;   // process number / count width
  localparam int DW     = 7;   // draw width, also dividend width
  localparam int TW     = 9;   // total weight width, n(n+1)/2 <= 496
  localparam int QW     = 7;   // share width, a share never exceeds 100
  localparam int LW     = 9;   // cumulative range bound width
  localparam int CW     = 32;  // counter width
  localparam int CNTW   = 3;   // division step counter width
  localparam int MAX_PROCESSES_DEF = 16;

  localparam logic [NW-1:0]   PC_RESET      = 5'd4;
  localparam logic [DW-1:0]   PERCENT_SCALE = 7'd100;
  localparam logic [DW-1:0]   DRAW_MAX      = 7'd99;
  localparam logic [CW-1:0]   COUNT_MAX     = '1;
  localparam logic [CNTW-1:0] DIV_LAST_CNT  = CNTW'(DW - 1);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_WALK,
    OP_READ,
    OP_UPDATE
  } lds_op_t;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_IN_FIRE,
    CND_DIV_LAST,
    CND_FOUND,
    CND_OUT_FREE
  } lds_cond_t;

  typedef logic [2:0] lds_step_t;

  localparam lds_step_t ST_LOAD     = 3'd0;
  localparam lds_step_t ST_DIV_INIT = 3'd1;
  localparam lds_step_t ST_DIV      = 3'd2;
  localparam lds_step_t ST_WALK     = 3'd3;
  localparam lds_step_t ST_READ     = 3'd4;
  localparam lds_step_t ST_WAIT     = 3'd5;
  localparam lds_step_t ST_UPDATE   = 3'd6;

  // One control word: datapath op, condition to leave, step to go to.
  typedef struct packed {
    lds_op_t   op;
    lds_cond_t cond;
    lds_step_t nxt;
  } lds_uword_t;

  typedef struct packed {
    logic in_fire;
    logic div_last;
    logic found;
    logic out_free;
  } lds_stat_t;

  typedef struct packed {
    lds_op_t op;
    logic    go;
  } lds_ctl_t;

  // Control store: a step repeats until its condition holds.
  function automatic lds_uword_t lds_rom(input lds_step_t step);
    lds_uword_t w;
    unique case (step)
      ST_LOAD:     w = '{op: OP_LOAD,     cond: CND_IN_FIRE,  nxt: ST_DIV_INIT};
      ST_DIV_INIT: w = '{op: OP_DIV_INIT, cond: CND_ALWAYS,   nxt: ST_DIV};
      ST_DIV:      w = '{op: OP_DIV_STEP, cond: CND_DIV_LAST, nxt: ST_WALK};
      ST_WALK:     w = '{op: OP_WALK,     cond: CND_FOUND,    nxt: ST_READ};
      ST_READ:     w = '{op: OP_READ,     cond: CND_ALWAYS,   nxt: ST_WAIT};
      ST_WAIT:     w = '{op: OP_NONE,     cond: CND_ALWAYS,   nxt: ST_UPDATE};
      ST_UPDATE:   w = '{op: OP_UPDATE,   cond: CND_OUT_FREE, nxt: ST_LOAD};
      default:     w = '{op: OP_NONE,     cond: CND_ALWAYS,   nxt: ST_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/lds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/lds_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module lds_seq import lds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lds_stat_t stat_i,
  output lds_ctl_t  ctl_o
);

  lds_step_t  pc_r, pc_nxt;
  lds_uword_t uw;
  logic       go;

  always_comb begin
    uw = lds_rom(pc_r);
    unique case (uw.cond)
      CND_ALWAYS:   go = 1'b1;
      CND_IN_FIRE:  go = stat_i.in_fire;
      CND_DIV_LAST: go = stat_i.div_last;
      CND_FOUND:    go = stat_i.found;
      CND_OUT_FREE: go = stat_i.out_free;
      default:      go = 1'b0;
    endcase
    // hold the step until its condition holds
    pc_nxt = go ? uw.nxt : pc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl_o = '{op: uw.op, go: go};

endmodule

// ===== hw/rtl/lottery_draw_scheduler_core.sv =====
// Lottery draw scheduler top level: datapath, tally store and result register.
//
// Each input word carries one random draw (0..99; larger values count as 99).
// Process k of n = clamp(process_count, 1, MAX_PROCESSES) owns a range of
// ceil(100*k/total) percent, total = n(n+1)/2, laid end to end in process
// order; the winner is the first process whose range holds the draw. The
// result word gives the winner, its saturating win tally and the saturating
// draw count. One draw is in flight at a time. An accepted word is loaded,
// then the block sets up, runs the shift-subtract division of 100 by the total
// weight and walks the ranges one process at a time up to the winner, each
// step advancing the ceiling share incrementally from quotient and remainder,
// then does a read, a wait and an update of the tally RAM before it can accept
// the next word. The result sits in an output register, so the next draw is
// accepted while a result still waits to be taken; the update step holds only
// if the previous result has not been taken. Tallies live in a RAM with one
// valid flip-flop per entry cleared at reset, so no clearing pass is needed.
// process_count (reset 4) is written with cfg_we; the user is to write it only
// while the block is idle, which the block does not enforce. Tallies survive a
// change of the count.
`include "lottery_draw_scheduler_core_defines.svh"

module lottery_draw_scheduler_core import lds_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_draw_value,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [NW-1:0] out_winner,
  output logic [CW-1:0] out_winner_tally,
  output logic [CW-1:0] out_draw_total,
  input  logic          cfg_we,
  input  logic [NW-1:0] cfg_wdata
);

  localparam int AW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int IW    = (AW > NW) ? AW : NW;
  localparam int NMAX  = (1 << NW) - 1;
  localparam int NCAP  = (MAX_PROCESSES < NMAX) ? MAX_PROCESSES : NMAX;

  // Sequencer handshake
  lds_ctl_t  ctl;
  lds_stat_t stat;

  // Configuration and counters
  logic [NW-1:0]            proc_cnt_r;
  logic [CW-1:0]            draw_cnt_r;
  logic [MAX_PROCESSES-1:0] vld_r;

  // Per-draw working registers
  logic [NW-1:0]   n_r;
  logic [DW-1:0]   draw_r;
  logic [TW-1:0]   t_r;
  logic [TW-1:0]   rem_r;
  logic [DW-1:0]   dvd_r;
  logic [QW-1:0]   quo_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   k_r;
  logic [QW-1:0]   q_r;
  logic [TW-1:0]   r_r;
  logic [LW-1:0]   lower_r;
  logic [NW-1:0]   winner_r;
  logic            rd_vld_r;

  // Result register
  logic          out_valid_r;
  logic [NW-1:0] out_winner_r;
  logic [CW-1:0] out_tally_r;
  logic [CW-1:0] out_total_r;

  // Combinational datapath
  logic [NW-1:0]   n_eff;
  logic [10:0]     t_prod;
  logic [TW-1:0]   t_calc;
  logic [DW-1:0]   draw_sat;
  logic [TW:0]     trial;
  logic            div_ge;
  logic [TW-1:0]   rem_nxt;
  logic [TW:0]     r_sum;
  logic            carry;
  logic [TW-1:0]   r_nxt;
  logic [QW-1:0]   q_nxt;
  logic [LW-1:0]   upper;
  logic [NW-1:0]   k_nxt;
  logic            found;
  logic [NW-1:0]   win_m1;
  logic [IW-1:0]   widx_ext;
  logic [AW-1:0]   tidx;
  logic [CW-1:0]   ram_rdata;
  logic [CW-1:0]   tally_old;
  logic [CW-1:0]   tally_nxt;
  logic [CW-1:0]   draw_cnt_nxt;
  logic            load_fire;
  logic            upd_fire;
  logic            out_free;

  // Clamp the process count to 1..MAX_PROCESSES, then total weight n(n+1)/2.
  always_comb begin
    if (proc_cnt_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(proc_cnt_r) > NCAP) begin
      n_eff = NW'(NCAP);
    end else begin
      n_eff = proc_cnt_r;
    end
    t_prod   = 11'(n_eff) * 11'({1'b0, n_eff} + 6'd1);
    t_calc   = t_prod[TW:1];
    draw_sat = (in_draw_value > DRAW_MAX) ? DRAW_MAX : in_draw_value;
  end

  // One shift-subtract step of 100 / total: quotient a, remainder b.
  always_comb begin
    trial   = {rem_r, dvd_r[DW-1]};
    div_ge  = trial >= {1'b0, t_r};
    rem_nxt = div_ge ? TW'(trial - {1'b0, t_r}) : TW'(trial);
  end

  // Walk step: ceil(100k/T) advances by a plus a carry out of the remainder.
  always_comb begin
    r_sum   = {1'b0, r_r} + {1'b0, rem_r};
    carry   = r_sum >= {1'b0, t_r};
    r_nxt   = carry ? TW'(r_sum - {1'b0, t_r}) : TW'(r_sum);
    q_nxt   = q_r + quo_r + QW'(carry);
    upper   = lower_r + LW'(q_nxt);
    k_nxt   = k_r + NW'(1);
    found   = (LW'(draw_r) < upper) || (k_nxt == n_r);
  end

  // Tally address from the winner number.
  always_comb begin
    win_m1   = winner_r - NW'(1);
    widx_ext = IW'(win_m1);
    tidx     = widx_ext[AW-1:0];
  end

  // Saturating counter updates.
  always_comb begin
    tally_old    = rd_vld_r ? ram_rdata : '0;
    tally_nxt    = (tally_old == COUNT_MAX) ? tally_old : tally_old + CW'(1);
    draw_cnt_nxt = (draw_cnt_r == COUNT_MAX) ? draw_cnt_r : draw_cnt_r + CW'(1);
  end

  assign in_ready  = (ctl.op == OP_LOAD);
  assign out_free  = !out_valid_r || out_ready;
  assign load_fire = (ctl.op == OP_LOAD) && ctl.go;
  assign upd_fire  = (ctl.op == OP_UPDATE) && ctl.go;

  assign stat = '{
    in_fire:  in_valid && in_ready,
    div_last: cnt_r == '0,
    found:    found,
    out_free: out_free
  };

  lds_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  lds_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_PROCESSES),
    .AW    (AW)
  ) u_tally_ram (
    .clk   (clk),
    .we    (upd_fire),
    .waddr (tidx),
    .wdata (tally_nxt),
    .re    (ctl.op == OP_READ),
    .raddr (tidx),
    .rdata (ram_rdata)
  );

  // Control state: configuration, draw count, tally valid bits, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_cnt_r  <= PC_RESET;
      draw_cnt_r  <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        proc_cnt_r <= cfg_wdata;
      end
      if (upd_fire) begin
        draw_cnt_r  <= draw_cnt_nxt;
        vld_r[tidx] <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, driven by the current control word.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        if (load_fire) begin
          n_r    <= n_eff;
          t_r    <= t_calc;
          draw_r <= draw_sat;
        end
      end
      OP_DIV_INIT: begin
        rem_r   <= '0;
        dvd_r   <= PERCENT_SCALE;
        quo_r   <= '0;
        cnt_r   <= DIV_LAST_CNT;
        k_r     <= '0;
        q_r     <= '0;
        r_r     <= t_r - TW'(1);
        lower_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DW-2:0], 1'b0};
        quo_r <= {quo_r[QW-2:0], div_ge};
        cnt_r <= cnt_r - CNTW'(1);
      end
      OP_WALK: begin
        k_r     <= k_nxt;
        q_r     <= q_nxt;
        r_r     <= r_nxt;
        lower_r <= upper;
        if (found) begin
          winner_r <= k_nxt;
        end
      end
      OP_READ: begin
        rd_vld_r <= vld_r[tidx];
      end
      OP_UPDATE: begin
        if (ctl.go) begin
          out_winner_r <= winner_r;
          out_tally_r  <= tally_nxt;
          out_total_r  <= draw_cnt_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_winner       = out_winner_r;
  assign out_winner_tally = out_tally_r;
  assign out_draw_total   = out_total_r;

  // One draw in flight: the load step is left right after an accept.
  `LDS_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second draw accepted while busy")
  // The walk always stops inside 1..n.
  `LDS_ASSERT_IMP(a_winner_range, upd_fire, (winner_r != '0) && (winner_r <= n_r), "winner out of range")
  // No process can win more often than there were draws.
  `LDS_ASSERT_IMP(a_tally_bound, out_valid, out_winner_tally <= out_draw_total, "tally exceeds draw count")
  // The draw count never goes backward.
  `LDS_ASSERT_NXT(a_count_mono, 1'b1, draw_cnt_r >= $past(draw_cnt_r), "draw count decreased")

endmodule
